/* rtl/tdp_pkg.sv */
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths, constants and types of the two-delta TLB prefetcher.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int VPN_W            = 52;
  localparam int TAG_W            = 32;
  localparam int DIST_W           = VPN_W + 1;
  localparam int SUM_W            = VPN_W + 2;
  localparam int PAGE_OFFSET_BITS = 12;
  // pages above (2^64 - 1) >> PAGE_OFFSET_BITS are out of range
  localparam int VPN_RANGE_BITS   = 64 - PAGE_OFFSET_BITS;
  localparam int PAYLOAD_W        = VPN_W + TAG_W;
  localparam int TDATA_W          = ((PAYLOAD_W + 7) / 8) * 8;

  typedef logic [VPN_W-1:0]  vpn_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [DIST_W-1:0] dist_t;

  // prefetch candidates of one miss, packed so that second_v implies first_v
  typedef struct packed {
    logic first_v;
    logic second_v;
    vpn_t first_vpn;
    vpn_t second_vpn;
  } cand_t;

endpackage

/* rtl/tdp_hist.sv */
// ----------------------------------------------------------------------------
// tdp_hist
// Miss history (previous page and distance) and candidate page generation.
// ----------------------------------------------------------------------------
module tdp_hist (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  logic           item_hit,
  input  tdp_pkg::vpn_t  item_vpn,
  input  logic           advance,
  output tdp_pkg::cand_t cand
);

  tdp_pkg::vpn_t  last_page_r, last_page_nxt;
  logic           page_known_r, page_known_nxt;
  tdp_pkg::dist_t last_stride_r, last_stride_nxt;
  logic           stride_known_r, stride_known_nxt;

  tdp_pkg::dist_t              new_dist;
  logic [tdp_pkg::SUM_W-1:0]   sum0;
  logic [tdp_pkg::SUM_W-1:0]   sum1;
  logic                        in_range0;
  logic                        in_range1;
  logic                        keep0;
  logic                        keep1;
  logic                        emit;

  // exact signed distance between two pages
  assign new_dist = {1'b0, item_vpn} - {1'b0, last_page_r};

  // candidate pages: current page plus new and previous distance
  assign sum0 = {2'b00, item_vpn} + {new_dist[tdp_pkg::DIST_W-1], new_dist};
  assign sum1 = {2'b00, item_vpn}
              + {last_stride_r[tdp_pkg::DIST_W-1], last_stride_r};

  // negative sums have the top bit set, so one zero test covers both bounds
  assign in_range0 = (sum0[tdp_pkg::SUM_W-1:tdp_pkg::VPN_RANGE_BITS] == '0);
  assign in_range1 = (sum1[tdp_pkg::SUM_W-1:tdp_pkg::VPN_RANGE_BITS] == '0);

  // zero distance gives the current page; equal distances repeat a page
  assign emit  = item_valid && !item_hit && page_known_r && stride_known_r;
  assign keep0 = emit && in_range0 && (new_dist != '0);
  assign keep1 = emit && in_range1 && (last_stride_r != '0)
              && !(keep0 && (new_dist == last_stride_r));

  // pack surviving candidates to the front
  always_comb begin
    cand.first_v    = keep0 || keep1;
    cand.second_v   = keep0 && keep1;
    cand.first_vpn  = keep0 ? sum0[tdp_pkg::VPN_W-1:0] : sum1[tdp_pkg::VPN_W-1:0];
    cand.second_vpn = sum1[tdp_pkg::VPN_W-1:0];
  end

  // history update on each miss that leaves the input stage
  always_comb begin
    last_page_nxt    = last_page_r;
    page_known_nxt   = page_known_r;
    last_stride_nxt  = last_stride_r;
    stride_known_nxt = stride_known_r;
    if (advance && item_valid && !item_hit) begin
      last_page_nxt  = item_vpn;
      page_known_nxt = 1'b1;
      if (page_known_r) begin
        last_stride_nxt  = new_dist;
        stride_known_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_page_r    <= '0;
      page_known_r   <= 1'b0;
      last_stride_r  <= '0;
      stride_known_r <= 1'b0;
    end else begin
      last_page_r    <= last_page_nxt;
      page_known_r   <= page_known_nxt;
      last_stride_r  <= last_stride_nxt;
      stride_known_r <= stride_known_nxt;
    end
  end

endmodule

/* rtl/tdp_pair.sv */
// ----------------------------------------------------------------------------
// tdp_pair
// Result register holding up to two prefetches of one miss, sent one a cycle while out_tready is high.
// ----------------------------------------------------------------------------
module tdp_pair (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  tdp_pkg::cand_t              cand,
  input  tdp_pkg::tag_t               tag,
  output logic                        free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tdp_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  logic          v0_r, v0_nxt;
  logic          v1_r, v1_nxt;
  tdp_pkg::vpn_t vpn0_r, vpn0_nxt;
  tdp_pkg::vpn_t vpn1_r, vpn1_nxt;
  tdp_pkg::tag_t tag_r, tag_nxt;
  tdp_pkg::vpn_t head_vpn;
  logic          out_fire;

  // head of the pair drives the port
  assign out_tvalid = v0_r || v1_r;
  assign out_tlast  = !(v0_r && v1_r);
  assign head_vpn   = v0_r ? vpn0_r : vpn1_r;
  assign out_tdata  = {{(tdp_pkg::TDATA_W - tdp_pkg::PAYLOAD_W){1'b0}}, tag_r, head_vpn};
  assign out_fire   = out_tvalid && out_tready;

  // empty now or emptied by this cycle's final item
  assign free = !out_tvalid || (out_fire && out_tlast);

  // only an item with at least one prefetch replaces the pair contents
  always_comb begin
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    vpn0_nxt = vpn0_r;
    vpn1_nxt = vpn1_r;
    tag_nxt  = tag_r;
    if (out_fire) begin
      if (v0_r) begin
        v0_nxt = 1'b0;
      end else begin
        v1_nxt = 1'b0;
      end
    end
    if (load && cand.first_v) begin
      v0_nxt   = cand.first_v;
      v1_nxt   = cand.second_v;
      vpn0_nxt = cand.first_vpn;
      vpn1_nxt = cand.second_vpn;
      tag_nxt  = tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    vpn0_r <= vpn0_nxt;
    vpn1_r <= vpn1_nxt;
    tag_r  <= tag_nxt;
  end

  // first of two items sent: the second follows as the last of its run
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && v0_r && v1_r |=> out_tvalid && out_tlast && !v0_r)
    else $error("second prefetch lost after first was sent");

  // the two prefetches of one miss never repeat a page
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r && v1_r |-> vpn0_r != vpn1_r)
    else $error("pair holds the same page twice");

  // a load only happens when the pair is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load && cand.first_v |-> free)
    else $error("pair overwritten while results pending");

endmodule

/* rtl/tlb_two_delta_prefetcher.sv */
// ----------------------------------------------------------------------------
// tlb_two_delta_prefetcher
// Two-delta TLB prefetcher: issues up to two prefetch pages per L2 TLB miss.
// ----------------------------------------------------------------------------
// datapath: a lookup is held in the input register, then its prefetches in the result pair register that drives out_*
// throughput: one lookup per cycle for hits and zero-result misses; one prefetch
//   per cycle out of the result pair register while out_tready is high; a miss
//   with prefetches waits in the input register while the pair is busy
// reset: synchronous active-low rst_n clears miss history and all valid flags
module tlb_two_delta_prefetcher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tdp_pkg::TDATA_W-1:0] in_tdata,   // lookup_vpn, request_tag, zero pad
  input  logic                        in_tuser,   // lookup_hit
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tdp_pkg::TDATA_W-1:0] out_tdata,  // prefetch_vpn, prefetch_tag, zero pad
  output logic                        out_tlast
);

  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_hit_r;
  tdp_pkg::vpn_t  s1_vpn_r;
  tdp_pkg::tag_t  s1_tag_r;
  logic           s1_adv;
  logic           in_fire;
  logic           pair_free;
  tdp_pkg::cand_t cand;

  // input stage advances unless it has results and the pair is busy
  assign s1_adv    = s1_valid_r && (!cand.first_v || pair_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_hit_r <= in_tuser;
      s1_vpn_r <= in_tdata[tdp_pkg::VPN_W-1:0];
      s1_tag_r <= in_tdata[tdp_pkg::PAYLOAD_W-1:tdp_pkg::VPN_W];
    end
  end

  tdp_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_hit   (s1_hit_r),
    .item_vpn   (s1_vpn_r),
    .advance    (s1_adv),
    .cand       (cand)
  );

  tdp_pair u_pair (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .cand       (cand),
    .tag        (s1_tag_r),
    .free       (pair_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* verif/tdp_prefetch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_prefetch_checker
// Watches the lookup and prefetch streams of the two-delta TLB prefetcher,
// predicts the prefetch pages of every accepted miss from its own copy of
// the miss history and compares each prefetch item field by field.
// ----------------------------------------------------------------------------
module tdp_prefetch_checker
  import tdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // lookup_vpn, request_tag, zero pad
  input  logic               in_tuser,   // lookup_hit
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,  // prefetch_vpn, prefetch_tag, zero pad
  input  logic               out_tlast,
  output int                 mismatches,
  output int                 pending,
  output int                 hits_seen,
  output int                 misses_seen,
  output int                 prefetches_seen
);

  typedef struct packed {
    vpn_t page;
    tag_t tag;
    logic last;
  } prefetch_t;

  // miss history as the block should hold it
  vpn_t  miss_page    = '0;
  logic  miss_known   = 1'b0;
  dist_t prev_stride  = '0;
  logic  stride_known = 1'b0;

  prefetch_t expected_prefetches[$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    hits_seen       = 0;
    misses_seen     = 0;
    prefetches_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // two-delta prediction for one lookup, advancing the history
  task automatic predict_prefetches(input vpn_t page, input logic hit, input tag_t tag);
    dist_t     stride_now;
    dist_t     strides[2];
    vpn_t      picks[2];
    int        n_picks;
    longint    sum;
    vpn_t      cand;
    prefetch_t p;
    n_picks = 0;
    if (hit) return;
    // first miss only records the page
    if (!miss_known) begin
      miss_page  = page;
      miss_known = 1'b1;
      return;
    end
    stride_now = {1'b0, page} - {1'b0, miss_page};
    // second miss records the distance too
    if (!stride_known) begin
      prev_stride  = stride_now;
      stride_known = 1'b1;
      miss_page    = page;
      return;
    end
    strides[0] = stride_now;
    strides[1] = prev_stride;
    for (int i = 0; i < 2; i++) begin
      sum = longint'(page) + longint'($signed(strides[i]));
      // out of page range
      if (sum < 0 || (sum >> VPN_RANGE_BITS) != 0) continue;
      // same page as the miss itself
      if (sum == longint'(page)) continue;
      cand = sum[VPN_W-1:0];
      // second candidate repeating the first
      if (n_picks == 1 && picks[0] == cand) continue;
      picks[n_picks] = cand;
      n_picks++;
    end
    for (int i = 0; i < n_picks; i++) begin
      p.page = picks[i];
      p.tag  = tag;
      p.last = (i == n_picks - 1);
      expected_prefetches = {expected_prefetches, p};
    end
    prev_stride = stride_now;
    miss_page   = page;
  endtask

  // sample both streams at the rising edge
  always @(posedge clk) begin
    prefetch_t want;
    vpn_t      got_page;
    tag_t      got_tag;
    if (!rst_n) begin
      miss_page    = '0;
      miss_known   = 1'b0;
      prev_stride  = '0;
      stride_known = 1'b0;
      expected_prefetches.delete();
    end else begin
      // compare a prefetch item with the oldest expectation
      if (out_tvalid && out_tready) begin
        got_page = out_tdata[VPN_W-1:0];
        got_tag  = out_tdata[VPN_W+TAG_W-1:VPN_W];
        prefetches_seen++;
        if (expected_prefetches.size() == 0) begin
          report_mismatch("unexpected prefetch page", 64'(got_page), 64'd0);
        end else begin
          want = expected_prefetches.pop_front();
          if (got_page !== want.page) report_mismatch("prefetch_vpn", 64'(got_page), 64'(want.page));
          if (got_tag !== want.tag) report_mismatch("prefetch_tag", 64'(got_tag), 64'(want.tag));
          if (out_tlast !== want.last) report_mismatch("last_of_run", 64'(out_tlast), 64'(want.last));
        end
      end
      // predict from each accepted lookup item
      if (in_tvalid && in_tready) begin
        if (in_tuser) hits_seen++;
        else misses_seen++;
        predict_prefetches(in_tdata[VPN_W-1:0], in_tuser, in_tdata[VPN_W+TAG_W-1:VPN_W]);
      end
    end
    pending = expected_prefetches.size();
  end

endmodule

/* verif/tb_tlb_two_delta_prefetcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_two_delta_prefetcher
// Drives TLB lookup items into the two-delta prefetcher: a directed pass over
// range edges, equal and zero distances and hits, then stride runs with
// random content mixed with noise, under random idling on both streams, a
// long output hold-off, a stretch with no idling and a full drain. A separate
// checker predicts and compares the prefetch items.
// ----------------------------------------------------------------------------
module tb_tlb_two_delta_prefetcher;
  import tdp_pkg::*;

  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   HOLD_CYCLES  = 300;
  localparam vpn_t MAX_PAGE     = {VPN_W{1'b1}};

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // lookup_vpn, request_tag, zero pad
  logic               in_tuser;   // lookup_hit
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // prefetch_vpn, prefetch_tag, zero pad
  logic               out_tlast;

  int mismatches;
  int pending;
  int hits_seen;
  int misses_seen;
  int prefetches_seen;

  int   misses_sent = 0;
  int   hold_left   = 0;
  int   cycles      = 0;
  logic tx_steady   = 1'b0;
  logic rx_steady   = 1'b0;

  tlb_two_delta_prefetcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tdp_prefetch_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .pending         (pending),
    .hits_seen       (hits_seen),
    .misses_seen     (misses_seen),
    .prefetches_seen (prefetches_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d prefetches outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic vpn_t rand_vpn();
    return vpn_t'({$urandom, $urandom});
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // start pages: near zero, near the top, or anywhere
  function automatic vpn_t pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return vpn_t'($urandom_range(0, 63));
    if (r < 20) return MAX_PAGE - vpn_t'($urandom_range(0, 63));
    return rand_vpn();
  endfunction

  // strides: mostly small, some medium, some anywhere in 53 bits
  function automatic dist_t pick_stride();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return dist_t'($urandom_range(0, 32)) - dist_t'(16);
    if (r < 80) return dist_t'($urandom_range(0, 2097152)) - dist_t'(1048576);
    return dist_t'({$urandom, $urandom});
  endfunction

  // offer one lookup item and wait for it to be taken
  task automatic send_lookup(input vpn_t page, input logic hit, input tag_t tag);
    int                 gap;
    logic [TDATA_W-1:0] word;
    gap  = pick_gap();
    word = '0;
    word[VPN_W-1:0]           = page;
    word[VPN_W+TAG_W-1:VPN_W] = tag;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= hit;
    do @(posedge clk); while (!in_tready);
    if (!hit) misses_sent++;
  endtask

  // stop offering and wait until every prefetch has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (hold_left == 0 && pending == 0);
  endtask

  // constant-stride miss run with occasional stride changes and hits
  task automatic send_stride_run(input int run_len);
    vpn_t  page;
    dist_t stride;
    int    k;
    page   = pick_page();
    stride = pick_stride();
    for (k = 0; k < run_len; k++) begin
      if ($urandom_range(0, 99) < 15) send_lookup(rand_vpn(), 1'b1, $urandom);
      send_lookup(page, 1'b0, $urandom);
      if ($urandom_range(0, 99) < 10) stride = pick_stride();
      if ($urandom_range(0, 99) < 5) stride = '0;
      page = page + stride[VPN_W-1:0];
    end
  endtask

  // stride runs mixed with unrelated lookups
  task automatic send_random_lookups(input int n_misses);
    int goal;
    goal = misses_sent + n_misses;
    while (misses_sent < goal) begin
      if ($urandom_range(0, 99) < 20) send_lookup(rand_vpn(), 1'($urandom_range(0, 1)), $urandom);
      else send_stride_run($urandom_range(2, 12));
    end
  endtask

  // receiver: random stalls, plus the long hold-off when requested
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 94) ? $urandom_range(0, 2) : $urandom_range(15, 60);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: hits, range edges, equal and zero distances, tag extremes
    send_lookup(MAX_PAGE, 1'b1, '1);
    send_lookup('0, 1'b0, '0);
    send_lookup(vpn_t'(52'h5555555555555), 1'b1, '0);
    send_lookup(MAX_PAGE, 1'b0, '1);
    send_lookup('0, 1'b0, '1);
    send_lookup(vpn_t'(1), 1'b0, '0);
    send_lookup(vpn_t'(4), 1'b0, tag_t'(32'h89abcdef));
    send_lookup(vpn_t'(7), 1'b0, '1);
    send_lookup(vpn_t'(7), 1'b0, '0);
    send_lookup(vpn_t'(7), 1'b0, '1);
    send_lookup(MAX_PAGE - 1, 1'b0, '0);
    send_lookup(MAX_PAGE, 1'b0, '1);
    send_lookup(MAX_PAGE - 2, 1'b0, '0);
    send_lookup(vpn_t'(12345), 1'b1, tag_t'(32'h12345678));
    send_lookup(MAX_PAGE - 1, 1'b0, '1);
    send_lookup(vpn_t'(52'h8000000000000), 1'b0, tag_t'(32'h55555555));
    send_lookup(vpn_t'(52'haaaaaaaaaaaaa), 1'b0, tag_t'(32'haaaaaaaa));
    send_lookup(vpn_t'(52'h5555555555555), 1'b0, tag_t'(32'h55555555));
    send_lookup(vpn_t'(52'h7ffffffffffff), 1'b0, '0);
    drain_results();

    // random, idling on both sides
    send_random_lookups(210);

    // long output hold-off while the sender keeps pushing strided misses
    tx_steady = 1'b1;
    hold_left = HOLD_CYCLES;
    send_stride_run(40);
    tx_steady = 1'b0;
    drain_results();

    // a stretch with no idling at all
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_random_lookups(80);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    send_random_lookups(290);

    // drain and let the block settle
    rx_steady = 1'b1;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("lookups taken: %0d misses and %0d hits; %0d prefetch items compared",
             misses_seen, hits_seen, prefetches_seen);
    $display("included page range edges, equal and zero strides, a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
